FILE: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge.
`define SCIR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Trigger at one edge implies the consequence at the next.
`define SCIR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/scir_pkg.sv
package scir_pkg;

  localparam int unsigned SLOT_DEPTH_DEF = 1024;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned PTR_W   = 16;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] SLOTS_RST = CNT_W'(1000);
  localparam logic [PTR_W-1:0] ECODE_RST = PTR_W'(1001);

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE   = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_RESTART = 2'd0,
    ACT_OCCUPY  = 2'd1,
    ACT_REMAP   = 2'd2
  } act_t;

  // one map entry: live bit over packed index
  typedef struct packed {
    logic             live;
    logic [CNT_W-1:0] idx;
  } map_ent_t;

endpackage

FILE: hw/rtl/slot_compaction_index_remap_core.sv
// Channel | Direction | Handshake         | Word
// in_     | input     | in_valid/in_stall   | action, occupied, old_pointer
// out_    | output    | out_valid/out_stall | new_index, packed_count, gap_found, overflow
// cfg_    | input     | cfg_we              | cfg_index selects register, cfg_data
// One word per cycle while in_stall is low; a taken word passes the read stage, then
// the output register. The map memory read runs at the accepting edge, into the read stage.
// Synchronous active-low reset clears counters, flags and pipeline; the map
// memory is not cleared, entries are only read once written in the current job.
// out_stall holds the output register, then the read stage, then in_stall.

`include "assert_macros.svh"

module slot_compaction_index_remap_core
  import scir_pkg::*;
#(
  parameter int unsigned SLOT_DEPTH = SLOT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ACT_W-1:0]     in_action,
  input  logic                 in_occupied,
  input  logic [PTR_W-1:0]     in_old_pointer,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PTR_W-1:0]     out_new_index,
  output logic [CNT_W-1:0]     out_packed_count,
  output logic                 out_gap_found,
  output logic                 out_overflow
);

  localparam int unsigned AW = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;

  map_ent_t map_mem [SLOT_DEPTH];
  map_ent_t rd_q_r;

  logic [CNT_W-1:0] slots_r;
  logic [PTR_W-1:0] ecode_r;

  logic [CNT_W-1:0] loaded_r, loaded_nxt;
  logic [CNT_W-1:0] packed_r, packed_nxt;
  logic             empty_r, empty_nxt;
  logic             gap_r, gap_nxt;

  logic             s1_v_r;
  logic             s1_rd_r;
  logic             s1_asg_r;
  logic [CNT_W-1:0] s1_idx_r;
  logic [CNT_W-1:0] s1_cnt_r;
  logic             s1_gap_r;
  logic             s1_ovf_r;
  logic [PTR_W-1:0] s1_ecode_r;

  logic             out_v_r;
  logic [PTR_W-1:0] out_new_index_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic             out_gap_r;
  logic             out_ovf_r;

  logic             s1_go;
  logic             in_acc;
  logic [CNT_W-1:0] lim;
  logic             full;
  logic             ptr_ok;
  logic             wr_en, rd_en;
  logic             asg, ovf;
  map_ent_t         wr_ent;
  logic [PTR_W-1:0] s1_new_index;

  assign s1_go    = ~out_v_r | ~out_stall;
  assign in_stall = s1_v_r & ~s1_go;
  assign in_acc   = in_valid & ~in_stall;

  assign lim    = (32'(slots_r) > 32'(SLOT_DEPTH)) ? CNT_W'(SLOT_DEPTH) : slots_r;
  assign full   = loaded_r >= lim;
  assign ptr_ok = (in_old_pointer < PTR_W'(lim)) && (in_old_pointer < PTR_W'(loaded_r));

  assign wr_ent.live = in_occupied;
  assign wr_ent.idx  = packed_r;

  always_comb begin
    loaded_nxt = loaded_r;
    packed_nxt = packed_r;
    empty_nxt  = empty_r;
    gap_nxt    = gap_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    asg        = 1'b0;
    ovf        = 1'b0;
    if (in_acc) begin
      unique case (act_t'(in_action))
        ACT_RESTART: begin
          loaded_nxt = '0;
          packed_nxt = '0;
          empty_nxt  = 1'b0;
          gap_nxt    = 1'b0;
        end
        ACT_OCCUPY: begin
          if (full) begin
            ovf = 1'b1;
          end else begin
            wr_en      = 1'b1;
            loaded_nxt = loaded_r + 1'b1;
            if (in_occupied) begin
              asg        = 1'b1;
              packed_nxt = packed_r + 1'b1;
              gap_nxt    = gap_r | empty_r;
            end else begin
              empty_nxt = 1'b1;
            end
          end
        end
        ACT_REMAP: begin
          rd_en = ptr_ok;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[AW'(loaded_r)] <= wr_ent;
    end
    if (rd_en) begin
      rd_q_r <= map_mem[AW'(in_old_pointer)];
    end
  end

  always_comb begin
    if (s1_rd_r && rd_q_r.live) begin
      s1_new_index = PTR_W'(rd_q_r.idx);
    end else if (s1_asg_r) begin
      s1_new_index = PTR_W'(s1_idx_r);
    end else begin
      s1_new_index = s1_ecode_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= SLOTS_RST;
      ecode_r  <= ECODE_RST;
      loaded_r <= '0;
      packed_r <= '0;
      empty_r  <= 1'b0;
      gap_r    <= 1'b0;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOTS_IN_USE: slots_r <= cfg_data[CNT_W-1:0];
          REG_EMPTY_CODE:   ecode_r <= cfg_data;
          default: ;
        endcase
      end
      loaded_r <= loaded_nxt;
      packed_r <= packed_nxt;
      empty_r  <= empty_nxt;
      gap_r    <= gap_nxt;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_go) begin
        s1_v_r <= 1'b0;
      end
      if (s1_go) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rd_r    <= rd_en;
      s1_asg_r   <= asg;
      s1_idx_r   <= packed_r;
      s1_cnt_r   <= packed_nxt;
      s1_gap_r   <= gap_nxt;
      s1_ovf_r   <= ovf;
      s1_ecode_r <= ecode_r;
    end
    if (s1_go && s1_v_r) begin
      out_new_index_r <= s1_new_index;
      out_cnt_r       <= s1_cnt_r;
      out_gap_r       <= s1_gap_r;
      out_ovf_r       <= s1_ovf_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_new_index    = out_new_index_r;
  assign out_packed_count = out_cnt_r;
  assign out_gap_found    = out_gap_r;
  assign out_overflow     = out_ovf_r;

  `SCIR_ASSERT_ALWAYS(a_packed_le_loaded, packed_r <= loaded_r, "packed count above slots loaded")
  `SCIR_ASSERT_NEXT(a_read_staged, rd_en, s1_v_r && s1_rd_r, "map read lost its stage")
  `SCIR_ASSERT_NEXT(a_full_flags_ovf, in_acc && (in_action == ACT_OCCUPY) && full, s1_v_r && s1_ovf_r && !s1_asg_r, "slot limit not flagged")

endmodule

FILE: tb/sv/tb_slot_compaction_index_remap_core.sv
module tb_slot_compaction_index_remap_core
  import scir_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned SLOT_CAP = SLOT_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int N_SET = 7;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             occupied;
    logic [PTR_W-1:0] old_pointer;
  } slot_word_t;

  typedef struct packed {
    logic [PTR_W-1:0] new_index;
    logic [CNT_W-1:0] packed_count;
    logic             gap_found;
    logic             overflow;
  } remap_res_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SLOTS_IN_USE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ACT_W-1:0] in_action = ACT_RESTART;
  logic             in_occupied = 1'b0;
  logic [PTR_W-1:0] in_old_pointer = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [PTR_W-1:0] out_new_index;
  logic [CNT_W-1:0] out_packed_count;
  logic             out_gap_found;
  logic             out_overflow;

  slot_compaction_index_remap_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_occupied      (in_occupied),
    .in_old_pointer   (in_old_pointer),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_new_index    (out_new_index),
    .out_packed_count (out_packed_count),
    .out_gap_found    (out_gap_found),
    .out_overflow     (out_overflow)
  );

  always #5 clk = ~clk;

  // mirror of the block's state and registers
  int unsigned      map_idx [SLOT_CAP];
  bit               map_live [SLOT_CAP];
  int unsigned      slots_loaded = 0;
  int unsigned      packed_total = 0;
  bit               seen_empty = 1'b0;
  bit               gap_sticky = 1'b0;
  logic [CNT_W-1:0] cur_slots = SLOTS_RST;
  logic [PTR_W-1:0] cur_ecode = ECODE_RST;

  slot_word_t pending_words[$];
  remap_res_t predicted_results[$];
  slot_word_t on_bus;

  int  words_queued = 0;
  int  words_sent = 0;
  int  results_checked = 0;
  int  overflow_seen = 0;
  int  gap_seen = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  no_idle = 1'b0;
  int  hold_req = 0;
  int  hold_left = 0;

  function automatic int unsigned slot_limit();
    return (cur_slots > SLOT_CAP) ? SLOT_CAP : int'(cur_slots);
  endfunction

  task automatic predict_compaction(input slot_word_t w);
    int unsigned lim;
    remap_res_t  r;
    lim = slot_limit();
    r.new_index = cur_ecode;
    r.overflow = 1'b0;
    case (w.action)
      ACT_RESTART: begin
        slots_loaded = 0;
        packed_total = 0;
        seen_empty = 1'b0;
        gap_sticky = 1'b0;
      end
      ACT_OCCUPY: begin
        if (slots_loaded >= lim) begin
          r.overflow = 1'b1;
        end else begin
          if (w.occupied) begin
            map_idx[slots_loaded] = packed_total;
            map_live[slots_loaded] = 1'b1;
            r.new_index = PTR_W'(packed_total);
            packed_total++;
            if (seen_empty) gap_sticky = 1'b1;
          end else begin
            map_live[slots_loaded] = 1'b0;
            seen_empty = 1'b1;
          end
          slots_loaded++;
        end
      end
      ACT_REMAP: begin
        if (w.old_pointer < lim && w.old_pointer < slots_loaded && map_live[w.old_pointer])
          r.new_index = PTR_W'(map_idx[w.old_pointer]);
      end
      default: ;
    endcase
    r.packed_count = CNT_W'(packed_total);
    r.gap_found = gap_sticky;
    predicted_results.insert(predicted_results.size(), r);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_compaction(on_bus);
        words_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() != 0 && (no_idle || $urandom_range(0, 99) >= 9)) begin
          on_bus = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= on_bus.action;
          in_occupied <= on_bus.occupied;
          in_old_pointer <= on_bus.old_pointer;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    remap_res_t got;
    remap_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.new_index = out_new_index;
        got.packed_count = out_packed_count;
        got.gap_found = out_gap_found;
        got.overflow = out_overflow;
        results_checked++;
        if (got.overflow === 1'b1) overflow_seen++;
        if (got.gap_found === 1'b1) gap_seen++;
        if (predicted_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word with none expected: idx %0d cnt %0d gap %0b ovf %0b",
                     $realtime, got.new_index, got.packed_count, got.gap_found, got.overflow);
        end else begin
          want = predicted_results.pop_front();
          if (got.new_index !== want.new_index || got.packed_count !== want.packed_count ||
              got.gap_found !== want.gap_found || got.overflow !== want.overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp idx %0d cnt %0d gap %0b ovf %0b, got idx %0d cnt %0d gap %0b ovf %0b",
                       $realtime, want.new_index, want.packed_count, want.gap_found,
                       want.overflow, got.new_index, got.packed_count, got.gap_found,
                       got.overflow);
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (hold_req > 0) begin
        out_stall <= 1'b1;
        hold_left = hold_req - 1;
        hold_req = 0;
      end else begin
        out_stall <= !no_idle && ($urandom_range(0, 99) < 9);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               predicted_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push_word(input logic [ACT_W-1:0] a, input logic o, input logic [PTR_W-1:0] p);
    slot_word_t w;
    w.action = a;
    w.occupied = o;
    w.old_pointer = p;
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  task automatic push_noise();
    if ($urandom_range(0, 99) < 6)
      push_word(ACT_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                PTR_W'($urandom_range(0, 65535)));
  endtask

  task automatic queue_job(input bit restart, input int n_occ, input int n_remap,
                           input int span);
    int density;
    int sel;
    logic [PTR_W-1:0] ptr;
    density = ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(30, 95);
    if (restart)
      push_word(ACT_RESTART, 1'($urandom_range(0, 1)), PTR_W'($urandom_range(0, 65535)));
    repeat (n_occ) begin
      push_noise();
      push_word(ACT_OCCUPY, $urandom_range(0, 99) < density,
                PTR_W'($urandom_range(0, 65535)));
    end
    repeat (n_remap) begin
      push_noise();
      sel = $urandom_range(0, 9);
      if (sel < 7) ptr = PTR_W'($urandom_range(0, span));
      else if (sel < 9) ptr = PTR_W'(span + $urandom_range(0, 3));
      else ptr = PTR_W'($urandom_range(0, 65535));
      push_word(ACT_REMAP, 1'($urandom_range(0, 1)), ptr);
    end
  endtask

  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SLOTS_IN_USE) cur_slots = data[CNT_W-1:0];
    else cur_ecode = data;
  endtask

  initial begin
    logic [CFG_W-1:0] slot_set [N_SET];
    logic [CFG_W-1:0] ecode_set [N_SET];
    int lim;
    int n_occ;
    int start;
    bit first;

    slot_set = '{16'd1, 16'd1024, 16'hFFFF, 16'd0, 16'd37, 16'd200, 16'd1000};
    ecode_set = '{16'h0000, 16'hFFFF, 16'd1001, 16'h5A5A, 16'd3, 16'd0, 16'd1001};
    ecode_set[5] = CFG_W'($urandom_range(0, 65535));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(REG_SLOTS_IN_USE, 16'd4);
    write_reg(REG_EMPTY_CODE, 16'hFFFF);
    push_word(ACT_RESTART, 1'b0, 16'h0000);
    push_word(ACT_REMAP, 1'b0, 16'h0000);     // nothing loaded yet
    push_word(ACT_OCCUPY, 1'b1, 16'h0000);
    push_word(ACT_OCCUPY, 1'b0, 16'hFFFF);
    push_word(ACT_OCCUPY, 1'b1, 16'h0000);    // gap
    push_word(ACT_OCCUPY, 1'b1, 16'h0000);
    push_word(ACT_OCCUPY, 1'b1, 16'h0000);    // past the limit
    push_word(ACT_REMAP, 1'b0, 16'h0000);
    push_word(ACT_REMAP, 1'b1, 16'h0001);     // empty slot
    push_word(ACT_REMAP, 1'b0, 16'h0003);
    push_word(ACT_REMAP, 1'b0, 16'h0004);     // at the limit
    push_word(ACT_REMAP, 1'b0, 16'hFFFF);
    push_word(ACT_UNUSED, 1'b1, 16'hFFFF);
    push_word(ACT_RESTART, 1'b1, 16'hFFFF);
    push_word(ACT_OCCUPY, 1'b0, 16'h0000);
    push_word(ACT_REMAP, 1'b0, 16'h0000);
    push_word(ACT_REMAP, 1'b0, 16'h0001);     // not loaded
    push_word(ACT_OCCUPY, 1'b1, 16'h0000);
    push_word(ACT_REMAP, 1'b1, 16'h0001);

    for (int i = 0; i < N_SET; i++) begin
      wait_idle();
      no_idle = (i == 1);
      write_reg(REG_SLOTS_IN_USE, slot_set[i]);
      write_reg(REG_EMPTY_CODE, ecode_set[i]);
      lim = slot_limit();
      start = words_queued;
      first = 1'b1;
      if (i == 5) hold_req = 80;
      if (i == 1) begin
        queue_job(1'b1, lim + 3, 40, lim);
      end else begin
        while (words_queued - start < 90) begin
          n_occ = $urandom_range(0, (lim < 40) ? lim + 2 : 40);
          // first job at the raised limit continues the one left running
          queue_job(!(i == 4 && first), n_occ, $urandom_range(1, 20),
                    (i == 4 && first) ? lim : n_occ + 1);
          first = 1'b0;
        end
      end
    end

    wait_idle();
    repeat (6) @(posedge clk);
    $display("%0d words sent over %0d register settings, %0d results checked",
             words_sent, N_SET + 1, results_checked);
    $display("%0d overflow results, %0d results with gap flag, %0d mismatches",
             overflow_seen, gap_seen, mismatches);
    if (mismatches == 0 && predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
